// ===== rtl/scba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_pkg: shared types and constants of the size-class buffer allocator
// Holds class and slot geometry, register map codes, beat layouts and the
// lowest-free-slot search function.
// ----------------------------------------------------------------------------
package scba_pkg;

    localparam int NUM_CLASSES = 4;   // classes that take part in search
    localparam int MAX_SLOTS   = 64;  // hard cap on usable slots per class

    localparam int REG_CLASSES = 4;   // classes present in the register map
    localparam int MAP_BITS    = 64;  // bits of one in-use map word
    localparam int ACTIVE_CLASSES = (NUM_CLASSES < REG_CLASSES) ? NUM_CLASSES : REG_CLASSES;

    localparam int CLASS_W  = 2;
    localparam int SLOT_W   = 6;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic CFG_GROUP_SIZE  = 1'b0;  // indexes 0..3: class sizes
    localparam logic CFG_GROUP_COUNT = 1'b1;  // indexes 4..7: slot counts

    localparam logic [REG_CLASSES-1:0][SAMPLE_W-1:0] CLASS_SIZE_RST =
        {16'd512, 16'd256, 16'd128, 16'd64};
    localparam logic [REG_CLASSES-1:0][COUNT_W-1:0] SLOT_COUNT_RST =
        {7'd16, 7'd32, 7'd64, 7'd64};

    // operation codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic [REG_CLASSES-1:0][SAMPLE_W-1:0] class_size;
        logic [REG_CLASSES-1:0][COUNT_W-1:0]  slot_count;
    } cfg_t;

    typedef struct packed {
        logic                operation;
        logic [SAMPLE_W-1:0] requested_samples;
        logic [CLASS_W-1:0]  release_class;
        logic [SLOT_W-1:0]   release_slot;
    } item_t;

    typedef struct packed {
        logic                success;
        logic [CLASS_W-1:0]  granted_class;
        logic [SLOT_W-1:0]   granted_slot;
        logic [SAMPLE_W-1:0] granted_samples;
    } result_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] index;
    } pick_t;

    // Lowest set bit of a map word.
    function automatic pick_t lowest_set(input logic [MAP_BITS-1:0] vec);
        pick_t p;
        p.found = 1'b0;
        p.index = '0;
        for (int s = MAP_BITS - 1; s >= 0; s--) begin
            if (vec[s]) begin
                p.found = 1'b1;
                p.index = SLOT_W'(s);
            end
        end
        return p;
    endfunction

endpackage

// ===== rtl/scba_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_cfg: configuration register file
// Class sizes and slot counts, written through a plain write port.
// ----------------------------------------------------------------------------
module scba_cfg import scba_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic [CLASS_W-1:0] reg_sel;

    assign reg_sel = cfg_addr[CLASS_W-1:0];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr[CFG_ADDR_W-1])
                CFG_GROUP_SIZE:  cfg_next.class_size[reg_sel] = cfg_wdata[SAMPLE_W-1:0];
                CFG_GROUP_COUNT: cfg_next.slot_count[reg_sel] = cfg_wdata[COUNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.class_size <= CLASS_SIZE_RST;
            cfg_reg.slot_count <= SLOT_COUNT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/scba_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_core: in-use maps and single-pass grant/release decision
// Decides one held beat combinationally and commits the map change on fire.
// ----------------------------------------------------------------------------
module scba_core import scba_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    fire,
    output result_t res
);

    logic [REG_CLASSES-1:0][MAP_BITS-1:0] in_use_reg;
    logic [REG_CLASSES-1:0][MAP_BITS-1:0] in_use_next;

    logic [REG_CLASSES-1:0][MAP_BITS-1:0] usable;
    logic [REG_CLASSES-1:0][MAP_BITS-1:0] avail;
    pick_t [REG_CLASSES-1:0]              pick;
    logic [REG_CLASSES-1:0]               fits;

    logic               grant;
    logic [CLASS_W-1:0] grant_class;
    logic [SLOT_W-1:0]  grant_slot;
    logic               release_ok;

    // usable slots: below the programmed count and below the hard cap
    always_comb begin
        for (int c = 0; c < REG_CLASSES; c++) begin
            for (int s = 0; s < MAP_BITS; s++) begin
                usable[c][s] = (COUNT_W'(s) < cfg.slot_count[c]) && (s < MAX_SLOTS);
            end
            avail[c] = usable[c] & ~in_use_reg[c];
            pick[c]  = lowest_set(avail[c]);
            fits[c]  = (cfg.class_size[c] >= item.requested_samples) && pick[c].found;
        end
    end

    // first qualifying class wins
    always_comb begin
        grant       = 1'b0;
        grant_class = '0;
        grant_slot  = '0;
        for (int c = ACTIVE_CLASSES - 1; c >= 0; c--) begin
            if (fits[c]) begin
                grant       = 1'b1;
                grant_class = CLASS_W'(c);
                grant_slot  = pick[c].index;
            end
        end
    end

    assign release_ok = (int'(item.release_class) < ACTIVE_CLASSES) &&
                        usable[item.release_class][item.release_slot];

    always_comb begin
        res = '0;
        case (item.operation)
            OP_ALLOC: begin
                res.success = grant;
                if (grant) begin
                    res.granted_class   = grant_class;
                    res.granted_slot    = grant_slot;
                    res.granted_samples = cfg.class_size[grant_class];
                end
            end
            OP_RELEASE: res.success = release_ok;
            default:    res = '0;
        endcase
    end

    always_comb begin
        in_use_next = in_use_reg;
        if (fire) begin
            if (item.operation == OP_ALLOC && grant) begin
                in_use_next[grant_class][grant_slot] = 1'b1;
            end else if (item.operation == OP_RELEASE && release_ok) begin
                in_use_next[item.release_class][item.release_slot] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else begin
            in_use_reg <= in_use_next;
        end
    end

endmodule

// ===== rtl/size_class_buffer_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_buffer_allocator: segregated-fit buffer pool allocator
// Grants and releases fixed-size buffers out of four size classes.
// ----------------------------------------------------------------------------
// Each input beat is either an allocate (tuser = 0) carrying a sample count,
// or a release (tuser = 1) naming a class and slot. An allocate scans the
// classes from zero upward and takes the lowest free slot of the first class
// whose size covers the request and that has a free slot; the answer carries
// the class, slot and class buffer length, or success = 0 with all fields
// zero when nothing fits. A release clears the slot's in-use bit and answers
// success = 1, or success = 0 when the handle lies beyond the class's slot
// count. Every input beat yields exactly one output beat, in order.
// Throughput is one beat per clock while the answer side does not stall: a
// beat sits in an input register, the free-slot priority encode over the
// four 64-bit maps and the class pick run in one combinational pass, and the
// answer lands in the output register, from which it is taken, while the map
// is updated at the same edge, so the next beat sees it. The maps clear at
// reset; configuration must only be written while no beat is in flight.
// ----------------------------------------------------------------------------
module size_class_buffer_allocator import scba_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [15:0] requested_samples, [17:16] release_class,
                                             // [23:18] release_slot
    input  logic                  s_tuser,   // [0] operation

    // answer stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [1:0] granted_class, [7:2] granted_slot,
                                             // [23:8] granted_samples
    output logic                  m_tuser    // [0] success
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    fire;

    scba_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // output register free or draining this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // hold the accepted beat until it moves into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.operation         <= s_tuser;
            in_item_reg.requested_samples <= s_tdata[15:0];
            in_item_reg.release_class     <= s_tdata[17:16];
            in_item_reg.release_slot      <= s_tdata[23:18];
        end
    end

    scba_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_item_reg),
        .fire    (fire),
        .res     (res)
    );

    // advance the answer into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.success;
    assign m_tdata  = {out_reg.granted_samples, out_reg.granted_slot, out_reg.granted_class};

endmodule

// ===== sim/size_class_buffer_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_buffer_allocator_tb: self-checking bench of the buffer allocator
// Drives allocate and release beats, predicts every answer from a bench-side
// model of the size-class pool and compares each answer beat field by field.
// ----------------------------------------------------------------------------
// Layout of the run:
//   - a directed table at reset settings, walked by a loop: boundary requests,
//     out-of-range handles, release of a free slot, ignored fields;
//   - several random phases, each under its own pool settings (extremes,
//     zero sizes, zero and oversized slot counts, random) and its own idle
//     pattern on the request and answer sides;
//   - pool settings change only once every expected answer has come back.
// Random traffic is mostly allocate plus release of handles that were really
// granted, so classes fill up and drain; the rest is stray releases.
// ----------------------------------------------------------------------------
module size_class_buffer_allocator_tb;
    import scba_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;  // generous ceiling for the whole run
    localparam int SETTLE_TICKS = 6;       // settle time after every owed answer is back
    localparam int REPORT_MAX   = 10;      // mismatches printed in full

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [SLOT_W-1:0]  slot;
    } handle_t;

    typedef struct packed {
        item_t   req;
        logic    typed;   // 1: answer below is written out by hand
        result_t answer;
    } table_row_t;

    // clock, reset and DUT ports; every input starts at a known value
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;   // [15:0] requested_samples, [17:16] release_class,
                                             // [23:18] release_slot
    logic                  s_tuser   = 1'b0; // [0] operation
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;          // [1:0] granted_class, [7:2] granted_slot,
                                             // [23:8] granted_samples
    logic                  m_tuser;          // [0] success

    // bench-side copy of the pool: settings and in-use maps
    logic [SAMPLE_W-1:0] pool_size  [REG_CLASSES];
    logic [COUNT_W-1:0]  pool_count [REG_CLASSES];
    logic [MAP_BITS-1:0] pool_busy  [REG_CLASSES];

    result_t    pending_answers[$];  // answers owed by the DUT, oldest first
    handle_t    held_buffers[$];     // handles granted and not yet given back
    table_row_t directed_rows[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int answer_faults      = 0;
    int cycle_count        = 0;

    size_class_buffer_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Ceiling on run time: a hung handshake ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Answer-side backpressure, changed on the falling edge only.
    always @(negedge aclk) begin
        m_tready = (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // Pool model
    // ------------------------------------------------------------------

    // Slots a class may grant or release: the register clipped to both caps.
    function automatic int usable_slots(input int c);
        int n;
        n = pool_count[c];
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        if (n > MAP_BITS)  n = MAP_BITS;
        return n;
    endfunction

    // Work out the answer to one request and advance the maps.
    function automatic result_t predict_answer(input item_t req);
        result_t             r;
        logic [MAP_BITS-1:0] free_map;
        int                  n;
        r = '0;
        if (req.operation == OP_ALLOC) begin
            // first class that is big enough and has a free slot wins
            for (int c = 0; c < ACTIVE_CLASSES; c++) begin
                if (pool_size[c] < req.requested_samples) continue;
                n = usable_slots(c);
                free_map = ~pool_busy[c];
                if (n < MAP_BITS) free_map = free_map & ((64'd1 << n) - 64'd1);
                for (int s = 0; s < MAP_BITS; s++) begin
                    if (free_map[s]) begin
                        pool_busy[c][s]   = 1'b1;
                        r.success         = 1'b1;
                        r.granted_class   = CLASS_W'(c);
                        r.granted_slot    = SLOT_W'(s);
                        r.granted_samples = pool_size[c];
                        return r;
                    end
                end
            end
        end else if (int'(req.release_class) < ACTIVE_CLASSES &&
                     int'(req.release_slot) < usable_slots(int'(req.release_class))) begin
            // release of an already free slot is still accepted
            pool_busy[req.release_class][req.release_slot] = 1'b0;
            r.success = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Answer checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.success         = m_tuser;
            got.granted_class   = m_tdata[1:0];
            got.granted_slot    = m_tdata[7:2];
            got.granted_samples = m_tdata[23:8];
            if (pending_answers.size() == 0) begin
                answer_faults++;
                if (answer_faults <= REPORT_MAX)
                    $display("unexpected answer beat: success=%0d class=%0d slot=%0d samples=%0d",
                             got.success, got.granted_class, got.granted_slot,
                             got.granted_samples);
            end else begin
                want = pending_answers.pop_front();
                if (got.success !== want.success || got.granted_class !== want.granted_class ||
                    got.granted_slot !== want.granted_slot ||
                    got.granted_samples !== want.granted_samples) begin
                    answer_faults++;
                    if (answer_faults <= REPORT_MAX)
                        $display("answer mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                 want.success, want.granted_class, want.granted_slot,
                                 want.granted_samples, got.success, got.granted_class,
                                 got.granted_slot, got.granted_samples);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Offer one request beat, hold it until accepted, then book its answer.
    task automatic offer_request(input item_t req, input logic typed, input result_t typed_answer);
        result_t model_answer;
        // idle cycles in front of the beat; valid drops here and in drain_answers
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {req.release_slot, req.release_class, req.requested_samples};
        s_tuser  = req.operation;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);

        model_answer = predict_answer(req);
        pending_answers.push_back(typed ? typed_answer : model_answer);

        // keep the list of live handles in step with the pool
        if (model_answer.success && req.operation == OP_ALLOC) begin
            held_buffers.push_back({model_answer.granted_class, model_answer.granted_slot});
        end else if (model_answer.success) begin
            for (int i = held_buffers.size() - 1; i >= 0; i--)
                if (held_buffers[i] == {req.release_class, req.release_slot})
                    held_buffers.delete(i);
        end
    endtask

    // Drop valid and wait until every owed answer is back, then settle.
    task automatic drain_answers();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // Write all eight registers; the pool must be idle.
    task automatic load_pool_settings(input logic [REG_CLASSES-1:0][SAMPLE_W-1:0] sizes,
                                      input logic [REG_CLASSES-1:0][COUNT_W-1:0]  counts);
        for (int c = 0; c < REG_CLASSES; c++) begin
            @(negedge aclk);
            cfg_we    = 1'b1;
            cfg_addr  = {CFG_GROUP_SIZE, CLASS_W'(c)};
            cfg_wdata = sizes[c];
            pool_size[c] = sizes[c];
        end
        for (int c = 0; c < REG_CLASSES; c++) begin
            @(negedge aclk);
            cfg_we    = 1'b1;
            cfg_addr  = {CFG_GROUP_COUNT, CLASS_W'(c)};
            cfg_wdata = CFG_DATA_W'(counts[c]);
            pool_count[c] = counts[c];
        end
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Random settings: mostly small sizes and counts so classes run dry.
    task automatic load_random_settings();
        logic [REG_CLASSES-1:0][SAMPLE_W-1:0] sizes;
        logic [REG_CLASSES-1:0][COUNT_W-1:0]  counts;
        for (int c = 0; c < REG_CLASSES; c++) begin
            sizes[c] = ($urandom_range(3) == 0) ? SAMPLE_W'($urandom_range(1, 65535))
                                                : SAMPLE_W'($urandom_range(1, 700));
            case ($urandom_range(3))
                0:       counts[c] = COUNT_W'($urandom_range(65, 127));  // acts as the cap
                1:       counts[c] = COUNT_W'($urandom_range(0, 64));
                default: counts[c] = COUNT_W'($urandom_range(0, 10));
            endcase
        end
        load_pool_settings(sizes, counts);
    endtask

    // One random phase under the given idle pattern.
    task automatic run_phase(input int idle_pct, input int stall_pct, input int beats,
                             input logic hold_midway);
        item_t   req;
        int      roll;
        int      pick;
        int      c;
        result_t none;
        none = '0;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < beats; i++) begin
            // pause the sender once until the pipe is empty
            if (hold_midway && i == beats / 2) drain_answers();

            // background content in every field, ignored ones too
            req.requested_samples = SAMPLE_W'($urandom);
            req.release_class     = CLASS_W'($urandom);
            req.release_slot      = SLOT_W'($urandom);
            roll = $urandom_range(99);
            if (roll < 55 || (held_buffers.size() == 0 && roll < 90)) begin
                req.operation = OP_ALLOC;
                case ($urandom_range(4))
                    0: req.requested_samples = '0;
                    1: ;  // full-range random request
                    2: begin
                        // hug a class boundary: size - 1, size, size + 1
                        c = $urandom_range(REG_CLASSES - 1);
                        req.requested_samples = pool_size[c] + SAMPLE_W'($urandom_range(2))
                                                - SAMPLE_W'(1);
                    end
                    default: req.requested_samples = SAMPLE_W'($urandom_range(600));
                endcase
            end else if (roll < 90) begin
                req.operation     = OP_RELEASE;
                pick              = $urandom_range(held_buffers.size() - 1);
                req.release_class = held_buffers[pick].cls;
                req.release_slot  = held_buffers[pick].slot;
            end else begin
                req.operation = OP_RELEASE;  // stray handle
            end
            offer_request(req, 1'b0, none);
        end
        drain_answers();
    endtask

    // Append a row to the directed table.
    task automatic add_row(input logic op, input int samples, input int rcls, input int rslot,
                           input logic typed, input int ok, input int gcls, input int gslot,
                           input int gsamples);
        table_row_t row;
        row.req.operation          = op;
        row.req.requested_samples  = SAMPLE_W'(samples);
        row.req.release_class      = CLASS_W'(rcls);
        row.req.release_slot       = SLOT_W'(rslot);
        row.typed                  = typed;
        row.answer.success         = ok[0];
        row.answer.granted_class   = CLASS_W'(gcls);
        row.answer.granted_slot    = SLOT_W'(gslot);
        row.answer.granted_samples = SAMPLE_W'(gsamples);
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int c = 0; c < REG_CLASSES; c++) begin
            pool_size[c]  = CLASS_SIZE_RST[c];
            pool_count[c] = SLOT_COUNT_RST[c];
            pool_busy[c]  = '0;
        end

        // directed table at reset settings: sizes 64/128/256/512, counts 64/64/32/16
        //       op          samples rcls rslot typed ok  cls slot samples
        add_row(OP_ALLOC,          0,   0,    0, 1'b1, 1, 0, 0,    64);  // zero request
        add_row(OP_ALLOC,      65535,   0,    0, 1'b1, 0, 0, 0,     0);  // nothing big enough
        add_row(OP_ALLOC,         64,   0,    0, 1'b1, 1, 0, 1,    64);  // exact fit
        add_row(OP_ALLOC,         65,   0,    0, 1'b1, 1, 1, 0,   128);  // spills to class one
        add_row(OP_ALLOC,        512,   0,    0, 1'b1, 1, 3, 0,   512);  // largest class
        add_row(OP_ALLOC,        513,   0,    0, 1'b1, 0, 0, 0,     0);
        add_row(OP_RELEASE,        0,   3,   16, 1'b1, 0, 0, 0,     0);  // just past slot count
        add_row(OP_RELEASE,    65535,   3,   63, 1'b1, 0, 0, 0,     0);
        add_row(OP_RELEASE,        0,   0,    0, 1'b1, 1, 0, 0,     0);
        add_row(OP_RELEASE,        0,   0,    0, 1'b1, 1, 0, 0,     0);  // slot already free
        add_row(OP_ALLOC,          1,   0,    0, 1'b1, 1, 0, 0,    64);  // reuse lowest slot
        add_row(OP_RELEASE,        0,   2,   31, 1'b1, 1, 0, 0,     0);  // last usable slot
        add_row(OP_RELEASE,        0,   2,   32, 1'b1, 0, 0, 0,     0);
        add_row(OP_RELEASE,        0,   1,   63, 1'b1, 1, 0, 0,     0);
        add_row(OP_ALLOC,        257,   3,   63, 1'b1, 1, 3, 1,   512);  // release fields ignored
        add_row(OP_RELEASE,    65535,   1,    0, 1'b1, 1, 0, 0,     0);
        add_row(OP_ALLOC,        128,   0,    0, 1'b1, 1, 1, 0,   128);
        add_row(OP_ALLOC,        256,   2,    5, 1'b0, 0, 0, 0,     0);
        add_row(OP_RELEASE,        7,   2,    0, 1'b0, 0, 0, 0,     0);
        add_row(OP_ALLOC,      32768,   1,   42, 1'b0, 0, 0, 0,     0);
        add_row(OP_RELEASE,    43690,   0,   21, 1'b0, 0, 0, 0,     0);

        // hold reset, then release it on a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            offer_request(directed_rows[i].req, directed_rows[i].typed,
                          directed_rows[i].answer);
        drain_answers();

        // random phases: idle patterns none / sender / receiver / both
        run_phase(0, 0, 160, 1'b0);

        // extremes: zero-size class, one-sample class, full-range classes,
        // zero, oversized and single-slot counts (index 3 first)
        load_pool_settings({16'd65535, 16'd65535, 16'd1, 16'd0},
                           {7'd1, 7'd127, 7'd0, 7'd64});
        run_phase(66, 0, 160, 1'b0);

        load_pool_settings({16'd1, 16'd65535, 16'd64, 16'd64},
                           {7'd100, 7'd64, 7'd2, 7'd1});
        run_phase(0, 66, 160, 1'b0);

        load_random_settings();
        run_phase(35, 35, 160, 1'b0);

        // back to the reset values; maps keep whatever is still held
        load_pool_settings({16'd512, 16'd256, 16'd128, 16'd64},
                           {7'd16, 7'd32, 7'd64, 7'd64});
        run_phase(0, 0, 160, 1'b1);

        load_random_settings();
        run_phase(66, 0, 160, 1'b0);

        load_pool_settings({16'd40, 16'd30, 16'd20, 16'd10},
                           {7'd4, 7'd2, 7'd5, 7'd3});
        run_phase(0, 66, 160, 1'b0);

        load_random_settings();
        run_phase(35, 35, 160, 1'b0);

        if (answer_faults == 0 && pending_answers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
